### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the pixel raster op blender.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/prb_pkg.sv
// ----------------------------------------------------------------------------
// prb_pkg
// Types and constants for the pixel raster op and alpha blend pipeline.
// ----------------------------------------------------------------------------
package prb_pkg;

	localparam int unsigned COORD_W       = 14;
	localparam int unsigned COORD_LIMIT   = 16384;
	localparam int unsigned LUMA_R        = 308;
	localparam int unsigned LUMA_G        = 600;
	localparam int unsigned LUMA_B        = 116;
	localparam int unsigned LUMA_SUM_W    = 18;
	localparam int unsigned LUMA_SHIFT    = 10;
	localparam logic [7:0]  FULL_ALPHA    = 8'hFF;
	localparam logic [15:0] FULL_PROD     = 16'(255 * 255);
	localparam logic [31:0] HIGH_COLOR_RST = 32'd255;

	typedef enum logic [3:0] {
		MODE_COPY   = 4'd0,
		MODE_OVER   = 4'd1,
		MODE_ALPHA  = 4'd2,
		MODE_ERASE  = 4'd3,
		MODE_INVERT = 4'd4,
		MODE_ADD    = 4'd5,
		MODE_SUB    = 4'd6,
		MODE_BLEND  = 4'd7,
		MODE_MIN    = 4'd8,
		MODE_MAX    = 4'd9,
		MODE_SELECT = 4'd10
	} mode_t;

	typedef enum logic [2:0] {
		CFG_MODE        = 3'd0,
		CFG_LOW_COLOR   = 3'd1,
		CFG_HIGH_COLOR  = 3'd2,
		CFG_SRC_OPAQUE  = 3'd3,
		CFG_BLEND_EN    = 3'd4,
		CFG_CONST_ALPHA = 3'd5
	} cfg_idx_t;

	typedef enum logic [1:0] {
		LT_NONE,
		LT_MIN,
		LT_MAX
	} luma_test_t;

	typedef struct packed {
		logic [3:0]  mode;
		logic [31:0] low_color;
		logic [31:0] high_color;
		logic        src_opaque;
		logic        blend_en;
		logic        const_alpha;
	} cfg_t;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic               visible;
		logic [7:0]         sr;
		logic [7:0]         sg;
		logic [7:0]         sb;
		logic [7:0]         sa;
		logic [7:0]         dr;
		logic [7:0]         dg;
		logic [7:0]         db;
		logic               high_sel;
		logic [7:0]         cov;
	} pix_t;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic               wr;
		luma_test_t         luma_test;
		logic [7:0]         luma_s;
		logic [7:0]         luma_d;
		logic [7:0]         tr;
		logic [7:0]         tg;
		logic [7:0]         tb;
		logic [7:0]         alpha;
		logic [7:0]         dr;
		logic [7:0]         dg;
		logic [7:0]         db;
		logic [7:0]         cov;
	} rop_t;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic               wr;
		logic [7:0]         tr;
		logic [7:0]         tg;
		logic [7:0]         tb;
		logic [7:0]         dr;
		logic [7:0]         dg;
		logic [7:0]         db;
		logic [15:0]        prod;
	} prod_t;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic               wr;
		logic [7:0]         tr;
		logic [7:0]         tg;
		logic [7:0]         tb;
		logic [7:0]         dr;
		logic [7:0]         dg;
		logic [7:0]         db;
		logic [7:0]         alpha;
	} mixin_t;

	typedef struct packed {
		logic               wr;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [7:0]         r;
		logic [7:0]         g;
		logic [7:0]         b;
	} res_t;

endpackage

### hdl/prb_if.sv
// ----------------------------------------------------------------------------
// prb_if
// Valid/ready channels for pixel beats in and write beats out.
// ----------------------------------------------------------------------------
interface prb_pix_if;
	logic        valid;
	logic        ready;
	logic [13:0] pixel_x;
	logic [13:0] pixel_y;
	logic        visible;
	logic [7:0]  source_red;
	logic [7:0]  source_green;
	logic [7:0]  source_blue;
	logic [7:0]  source_alpha;
	logic [7:0]  dest_red;
	logic [7:0]  dest_green;
	logic [7:0]  dest_blue;
	logic        pattern_bit;
	logic [7:0]  coverage;

	modport source (
		output valid, pixel_x, pixel_y, visible, source_red, source_green,
			source_blue, source_alpha, dest_red, dest_green, dest_blue,
			pattern_bit, coverage,
		input  ready
	);
	modport sink (
		input  valid, pixel_x, pixel_y, visible, source_red, source_green,
			source_blue, source_alpha, dest_red, dest_green, dest_blue,
			pattern_bit, coverage,
		output ready
	);
endinterface

interface prb_res_if;
	logic        valid;
	logic        ready;
	logic        write_enable;
	logic [13:0] write_x;
	logic [13:0] write_y;
	logic [7:0]  result_red;
	logic [7:0]  result_green;
	logic [7:0]  result_blue;

	modport source (
		output valid, write_enable, write_x, write_y, result_red, result_green,
			result_blue,
		input  ready
	);
	modport sink (
		input  valid, write_enable, write_x, write_y, result_red, result_green,
			result_blue,
		output ready
	);
endinterface

### hdl/prb_rop.sv
// ----------------------------------------------------------------------------
// prb_rop
// Stage 1: visibility, drawing mode, target colour, pre-coverage alpha, luma.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module prb_rop
	import prb_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	input  logic  in_valid,
	output logic  in_ready,
	input  pix_t  in_pix,
	output logic  out_valid,
	input  logic  out_ready,
	output rop_t  out_s1
);

	logic                  valid_s1;
	rop_t                  data_s1;
	rop_t                  nxt;
	logic                  in_range;
	logic [7:0]            lr, lg, lb, la, hr, hg, hb, ha;
	logic [7:0]            ta;
	logic                  hit_high, hit_low;
	logic [8:0]            sum_r, sum_g, sum_b;
	logic [LUMA_SUM_W-1:0] luma_sum_s, luma_sum_d;

	assign {lr, lg, lb, la} = cfg.low_color;
	assign {hr, hg, hb, ha} = cfg.high_color;

	assign in_range = ({3'b0, in_pix.x} < 17'(COORD_LIMIT))
		&& ({3'b0, in_pix.y} < 17'(COORD_LIMIT));

	assign sum_r = {1'b0, in_pix.dr} + {1'b0, in_pix.sr};
	assign sum_g = {1'b0, in_pix.dg} + {1'b0, in_pix.sg};
	assign sum_b = {1'b0, in_pix.db} + {1'b0, in_pix.sb};

	assign hit_high = (in_pix.dr == hr) && (in_pix.dg == hg) && (in_pix.db == hb);
	assign hit_low  = (in_pix.dr == lr) && (in_pix.dg == lg) && (in_pix.db == lb);

	assign luma_sum_s = LUMA_SUM_W'(LUMA_R) * LUMA_SUM_W'(in_pix.sr)
		+ LUMA_SUM_W'(LUMA_G) * LUMA_SUM_W'(in_pix.sg)
		+ LUMA_SUM_W'(LUMA_B) * LUMA_SUM_W'(in_pix.sb);
	assign luma_sum_d = LUMA_SUM_W'(LUMA_R) * LUMA_SUM_W'(in_pix.dr)
		+ LUMA_SUM_W'(LUMA_G) * LUMA_SUM_W'(in_pix.dg)
		+ LUMA_SUM_W'(LUMA_B) * LUMA_SUM_W'(in_pix.db);

	always_comb begin
		nxt           = '0;
		nxt.x         = in_pix.x;
		nxt.y         = in_pix.y;
		nxt.wr        = in_pix.visible && in_range;
		nxt.luma_test = LT_NONE;
		nxt.luma_s    = luma_sum_s[LUMA_SUM_W-1:LUMA_SHIFT];
		nxt.luma_d    = luma_sum_d[LUMA_SUM_W-1:LUMA_SHIFT];
		nxt.tr        = in_pix.sr;
		nxt.tg        = in_pix.sg;
		nxt.tb        = in_pix.sb;
		nxt.dr        = in_pix.dr;
		nxt.dg        = in_pix.dg;
		nxt.db        = in_pix.db;
		nxt.cov       = in_pix.cov;
		ta            = in_pix.sa;
		unique case (cfg.mode)
			MODE_COPY: ta = FULL_ALPHA;
			MODE_ERASE: begin
				if (!in_pix.high_sel) nxt.wr = 1'b0;
				{nxt.tr, nxt.tg, nxt.tb} = {lr, lg, lb};
				ta = la;
			end
			MODE_INVERT: begin
				if (!in_pix.high_sel) nxt.wr = 1'b0;
				nxt.tr = ~in_pix.dr;
				nxt.tg = ~in_pix.dg;
				nxt.tb = ~in_pix.db;
				ta = FULL_ALPHA;
			end
			MODE_ADD: begin
				nxt.tr = sum_r[8] ? 8'hFF : sum_r[7:0];
				nxt.tg = sum_g[8] ? 8'hFF : sum_g[7:0];
				nxt.tb = sum_b[8] ? 8'hFF : sum_b[7:0];
				ta = FULL_ALPHA;
			end
			MODE_SUB: begin
				nxt.tr = (in_pix.dr > in_pix.sr) ? in_pix.dr - in_pix.sr : 8'd0;
				nxt.tg = (in_pix.dg > in_pix.sg) ? in_pix.dg - in_pix.sg : 8'd0;
				nxt.tb = (in_pix.db > in_pix.sb) ? in_pix.db - in_pix.sb : 8'd0;
				ta = FULL_ALPHA;
			end
			MODE_BLEND: begin
				nxt.tr = sum_r[8:1];
				nxt.tg = sum_g[8:1];
				nxt.tb = sum_b[8:1];
				ta = FULL_ALPHA;
			end
			MODE_MIN: nxt.luma_test = LT_MIN;
			MODE_MAX: nxt.luma_test = LT_MAX;
			MODE_SELECT: begin
				if (!in_pix.high_sel) begin
					nxt.wr = 1'b0;
				end else if (hit_high) begin
					{nxt.tr, nxt.tg, nxt.tb} = {lr, lg, lb};
					ta = la;
				end else if (hit_low) begin
					{nxt.tr, nxt.tg, nxt.tb} = {hr, hg, hb};
					ta = ha;
				end else begin
					nxt.wr = 1'b0;
				end
			end
			// over, alpha and the unused codes take the source as is
			default: ;
		endcase
		nxt.alpha = ta;
		if (cfg.src_opaque || (cfg.mode == MODE_COPY)) nxt.alpha = FULL_ALPHA;
		if (cfg.blend_en && cfg.const_alpha) nxt.alpha = ha;
	end

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) data_s1 <= nxt;
	end

	assign out_valid = valid_s1;
	assign out_s1    = data_s1;

	`ASSERT_NEXT(a_erase_needs_high, clk, arst_n,
		in_valid && in_ready && (cfg.mode == MODE_ERASE) && !in_pix.high_sel,
		valid_s1 && !data_s1.wr, "erase without pattern bit reached write")

endmodule

### hdl/prb_alpha.sv
// ----------------------------------------------------------------------------
// prb_alpha
// Stages 2 and 3: brightness test, alpha times coverage, divide by 255.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module prb_alpha
	import prb_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_ready,
	input  rop_t   in_s1,
	output logic   out_valid,
	input  logic   out_ready,
	output mixin_t out_s3
);

	logic   valid_s2, valid_s3;
	logic   ready_s3;
	prod_t  data_s2, nxt_s2;
	mixin_t data_s3, nxt_s3;
	logic   luma_ok;
	logic [16:0] div_sum;

	always_comb begin
		case (in_s1.luma_test)
			LT_MIN:  luma_ok = in_s1.luma_s < in_s1.luma_d;
			LT_MAX:  luma_ok = in_s1.luma_s > in_s1.luma_d;
			default: luma_ok = 1'b1;
		endcase
	end

	always_comb begin
		nxt_s2.x    = in_s1.x;
		nxt_s2.y    = in_s1.y;
		nxt_s2.wr   = in_s1.wr && luma_ok;
		nxt_s2.tr   = in_s1.tr;
		nxt_s2.tg   = in_s1.tg;
		nxt_s2.tb   = in_s1.tb;
		nxt_s2.dr   = in_s1.dr;
		nxt_s2.dg   = in_s1.dg;
		nxt_s2.db   = in_s1.db;
		nxt_s2.prod = 16'(in_s1.alpha) * 16'(in_s1.cov);
	end

	// floor(p / 255) = (p + (p >> 8) + 1) >> 8 for any product p of two 8-bit values
	assign div_sum = {1'b0, data_s2.prod} + 17'(data_s2.prod[15:8]) + 17'd1;

	always_comb begin
		nxt_s3.x     = data_s2.x;
		nxt_s3.y     = data_s2.y;
		nxt_s3.wr    = data_s2.wr;
		nxt_s3.tr    = data_s2.tr;
		nxt_s3.tg    = data_s2.tg;
		nxt_s3.tb    = data_s2.tb;
		nxt_s3.dr    = data_s2.dr;
		nxt_s3.dg    = data_s2.dg;
		nxt_s3.db    = data_s2.db;
		nxt_s3.alpha = div_sum[15:8];
	end

	assign ready_s3 = !valid_s3 || out_ready;
	assign in_ready = !valid_s2 || ready_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (in_ready) valid_s2 <= in_valid;
			if (ready_s3) valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) data_s2 <= nxt_s2;
		if (valid_s2 && ready_s3) data_s3 <= nxt_s3;
	end

	assign out_valid = valid_s3;
	assign out_s3    = data_s3;

	`ASSERT_NEXT(a_full_cover_opaque, clk, arst_n,
		valid_s2 && ready_s3 && (data_s2.prod == FULL_PROD),
		data_s3.alpha == FULL_ALPHA, "opaque full coverage lost alpha")

endmodule

### hdl/prb_blend.sv
// ----------------------------------------------------------------------------
// prb_blend
// Stage 4: per-channel mix of target and destination, output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module prb_blend
	import prb_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_ready,
	input  mixin_t in_s3,
	output logic   out_valid,
	input  logic   out_ready,
	output res_t   out_s4
);

	logic        valid_s4;
	res_t        data_s4, nxt;
	logic [8:0]  inv_a;
	logic [16:0] mix_r, mix_g, mix_b;

	assign inv_a = 9'd256 - {1'b0, in_s3.alpha};

	// s*a + d*(256-a), never above 255*256
	assign mix_r = 17'(in_s3.tr) * 17'(in_s3.alpha) + 17'(in_s3.dr) * 17'(inv_a);
	assign mix_g = 17'(in_s3.tg) * 17'(in_s3.alpha) + 17'(in_s3.dg) * 17'(inv_a);
	assign mix_b = 17'(in_s3.tb) * 17'(in_s3.alpha) + 17'(in_s3.db) * 17'(inv_a);

	always_comb begin
		nxt.wr = in_s3.wr;
		nxt.x  = in_s3.x;
		nxt.y  = in_s3.y;
		if (!in_s3.wr) begin
			{nxt.r, nxt.g, nxt.b} = '0;
		end else if (in_s3.alpha == FULL_ALPHA) begin
			{nxt.r, nxt.g, nxt.b} = {in_s3.tr, in_s3.tg, in_s3.tb};
		end else begin
			{nxt.r, nxt.g, nxt.b} = {mix_r[15:8], mix_g[15:8], mix_b[15:8]};
		end
	end

	assign in_ready = !valid_s4 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (in_ready) begin
			valid_s4 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) data_s4 <= nxt;
	end

	assign out_valid = valid_s4;
	assign out_s4    = data_s4;

	`ASSERT_IMPLIES(a_dropped_is_black, clk, arst_n, valid_s4 && !data_s4.wr,
		(data_s4.r == 8'd0) && (data_s4.g == 8'd0) && (data_s4.b == 8'd0),
		"unwritten pixel carries colour")

endmodule

### hdl/pixel_raster_op_blender_top.sv
// ----------------------------------------------------------------------------
// pixel_raster_op_blender_top
// Per-pixel raster operation and alpha blend unit, four register stages.
// ----------------------------------------------------------------------------
// Usage:
//   pix_in carries one pixel beat: position, visibility, source RGBA,
//   destination RGB, pattern bit and coverage. pix_out returns one write
//   beat per pixel: write enable, the echoed position and the new RGB
//   (the written alpha is always 255). Dropped pixels come out with write
//   enable low and black colour.
//   Registers are set through cfg_we / cfg_index / cfg_wdata while no
//   pixel is in flight; each write lands at the clock edge with cfg_we high.
//   A pixel accepted at the input moves through the stages in order and
//   waits in the output register until the receiver takes it. Stages are
//   mode/luma, alpha times coverage, divide by 255, channel mix.
//   Throughput is one pixel per clock while the receiver takes beats; every stage holds its own valid bit.
//   When the receiver holds ready low the output register keeps its beat
//   and earlier stages keep filling until full, so pix_in.ready drops only
//   when all four stages are occupied.
//   Reset empties the pipeline and loads the register defaults (copy mode,
//   high colour 255, all flags clear).
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pixel_raster_op_blender_top
	import prb_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [2:0]       cfg_index,
	input  logic [31:0]      cfg_wdata,
	prb_pix_if.sink          pix_in,
	prb_res_if.source        pix_out
);

	cfg_t   cfg_q;
	pix_t   pix;
	rop_t   rop_s1;
	mixin_t mix_s3;
	res_t   res_s4;
	logic   v1, r1, v3, r3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode        <= MODE_COPY;
			cfg_q.low_color   <= '0;
			cfg_q.high_color  <= HIGH_COLOR_RST;
			cfg_q.src_opaque  <= 1'b0;
			cfg_q.blend_en    <= 1'b0;
			cfg_q.const_alpha <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MODE:        cfg_q.mode        <= cfg_wdata[3:0];
				CFG_LOW_COLOR:   cfg_q.low_color   <= cfg_wdata;
				CFG_HIGH_COLOR:  cfg_q.high_color  <= cfg_wdata;
				CFG_SRC_OPAQUE:  cfg_q.src_opaque  <= cfg_wdata[0];
				CFG_BLEND_EN:    cfg_q.blend_en    <= cfg_wdata[0];
				CFG_CONST_ALPHA: cfg_q.const_alpha <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	assign pix.x        = pix_in.pixel_x;
	assign pix.y        = pix_in.pixel_y;
	assign pix.visible  = pix_in.visible;
	assign pix.sr       = pix_in.source_red;
	assign pix.sg       = pix_in.source_green;
	assign pix.sb       = pix_in.source_blue;
	assign pix.sa       = pix_in.source_alpha;
	assign pix.dr       = pix_in.dest_red;
	assign pix.dg       = pix_in.dest_green;
	assign pix.db       = pix_in.dest_blue;
	assign pix.high_sel = pix_in.pattern_bit;
	assign pix.cov      = pix_in.coverage;

	prb_rop u_rop (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (pix_in.valid),
		.in_ready  (pix_in.ready),
		.in_pix    (pix),
		.out_valid (v1),
		.out_ready (r1),
		.out_s1    (rop_s1)
	);

	prb_alpha u_alpha (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v1),
		.in_ready  (r1),
		.in_s1     (rop_s1),
		.out_valid (v3),
		.out_ready (r3),
		.out_s3    (mix_s3)
	);

	prb_blend u_blend (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v3),
		.in_ready  (r3),
		.in_s3     (mix_s3),
		.out_valid (pix_out.valid),
		.out_ready (pix_out.ready),
		.out_s4    (res_s4)
	);

	assign pix_out.write_enable = res_s4.wr;
	assign pix_out.write_x      = res_s4.x;
	assign pix_out.write_y      = res_s4.y;
	assign pix_out.result_red   = res_s4.r;
	assign pix_out.result_green = res_s4.g;
	assign pix_out.result_blue  = res_s4.b;

	`ASSERT_IMPLIES(a_stall_only_when_full, clk, arst_n, !pix_in.ready,
		pix_out.valid && !pix_out.ready, "input blocked with output free")

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the raster op / alpha blend unit beat by beat against an in-bench
// prediction of the write it should produce, over all drawing modes and
// random register settings, with random sender bursts and receiver stalls.
// ----------------------------------------------------------------------------
module testbench;
	import prb_pkg::*;

	localparam int unsigned CYCLE_LIMIT   = 300000;
	localparam int unsigned DRAIN_CYCLES  = 12;
	localparam int unsigned PHASE_PIXELS  = 70;
	localparam int unsigned LONG_HOLD     = 100;
	// mode codes with no mode of their own; they act like over
	localparam logic [3:0]  MODE_SPARE_LO = 4'd11;
	localparam logic [3:0]  MODE_SPARE_HI = 4'd15;
	localparam logic [31:0] DIR_LOW       = 32'h10203040;
	localparam logic [31:0] DIR_HIGH      = 32'hA0B0C080;

	typedef struct packed {
		logic [13:0] x;
		logic [13:0] y;
		logic        vis;
		logic [7:0]  sr;
		logic [7:0]  sg;
		logic [7:0]  sb;
		logic [7:0]  sa;
		logic [7:0]  dr;
		logic [7:0]  dg;
		logic [7:0]  db;
		logic        hi;
		logic [7:0]  cov;
	} pixel_beat_t;

	typedef struct packed {
		logic        we;
		logic [13:0] x;
		logic [13:0] y;
		logic [7:0]  r;
		logic [7:0]  g;
		logic [7:0]  b;
	} fb_write_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_wdata;

	prb_pix_if pix_ch ();
	prb_res_if res_ch ();

	pixel_raster_op_blender_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.pix_in    (pix_ch),
		.pix_out   (res_ch)
	);

	// shadow copy of the register file
	logic [3:0]  cur_mode        = MODE_COPY;
	logic [31:0] cur_low         = '0;
	logic [31:0] cur_high        = HIGH_COLOR_RST;
	logic        cur_opaque      = 1'b0;
	logic        cur_blend_en    = 1'b0;
	logic        cur_const_alpha = 1'b0;

	pixel_beat_t pixel_backlog[$];
	fb_write_t   expected_writes[$];
	pixel_beat_t drive_px       = '0;
	int unsigned burst_left     = 1;
	int unsigned gap_left       = 0;
	int unsigned writes_seen    = 0;
	int unsigned next_hold_mark = 100;
	int unsigned hold_left      = 0;
	int unsigned pat_age        = 0;
	logic [15:0] stall_pat      = '1;
	int unsigned err_count      = 0;
	int unsigned cycle_count    = 0;

	function automatic int unsigned luma_of(logic [7:0] r, logic [7:0] g, logic [7:0] b);
		return (LUMA_R * r + LUMA_G * g + LUMA_B * b) >> LUMA_SHIFT;
	endfunction

	function automatic logic [7:0] mix_channel(int unsigned d, int unsigned s, int unsigned a);
		return 8'((s * a + d * (256 - a)) >> 8);
	endfunction

	function automatic logic [7:0] sat_add(logic [7:0] d, logic [7:0] s);
		logic [8:0] sum;
		sum = {1'b0, d} + s;
		return sum[8] ? 8'hFF : sum[7:0];
	endfunction

	function automatic fb_write_t blend_pixel(pixel_beat_t p);
		fb_write_t   w;
		logic [7:0]  tr, tg, tb, ta;
		logic [7:0]  lr, lg, lb, la, hr, hg, hb, ha;
		logic        wr;
		int unsigned a;
		{lr, lg, lb, la} = cur_low;
		{hr, hg, hb, ha} = cur_high;
		tr = p.sr;
		tg = p.sg;
		tb = p.sb;
		ta = p.sa;
		wr = p.vis && p.x < COORD_LIMIT && p.y < COORD_LIMIT;
		if (wr) begin
			case (cur_mode)
				MODE_COPY: ta = FULL_ALPHA;
				MODE_ERASE: begin
					if (!p.hi)
						wr = 1'b0;
					{tr, tg, tb, ta} = cur_low;
				end
				MODE_INVERT: begin
					if (!p.hi)
						wr = 1'b0;
					tr = ~p.dr;
					tg = ~p.dg;
					tb = ~p.db;
					ta = FULL_ALPHA;
				end
				MODE_ADD: begin
					tr = sat_add(p.dr, p.sr);
					tg = sat_add(p.dg, p.sg);
					tb = sat_add(p.db, p.sb);
					ta = FULL_ALPHA;
				end
				MODE_SUB: begin
					tr = (p.dr > p.sr) ? p.dr - p.sr : 8'd0;
					tg = (p.dg > p.sg) ? p.dg - p.sg : 8'd0;
					tb = (p.db > p.sb) ? p.db - p.sb : 8'd0;
					ta = FULL_ALPHA;
				end
				MODE_BLEND: begin
					tr = 8'(({1'b0, p.dr} + p.sr) >> 1);
					tg = 8'(({1'b0, p.dg} + p.sg) >> 1);
					tb = 8'(({1'b0, p.db} + p.sb) >> 1);
					ta = FULL_ALPHA;
				end
				MODE_MIN: wr = luma_of(p.sr, p.sg, p.sb) < luma_of(p.dr, p.dg, p.db);
				MODE_MAX: wr = luma_of(p.sr, p.sg, p.sb) > luma_of(p.dr, p.dg, p.db);
				MODE_SELECT: begin
					// high colour match wins when both match
					if (!p.hi)
						wr = 1'b0;
					else if ({p.dr, p.dg, p.db} == {hr, hg, hb})
						{tr, tg, tb, ta} = cur_low;
					else if ({p.dr, p.dg, p.db} == {lr, lg, lb})
						{tr, tg, tb, ta} = cur_high;
					else
						wr = 1'b0;
				end
				default: ;
			endcase
		end
		w.we = wr;
		w.x  = p.x;
		w.y  = p.y;
		w.r  = '0;
		w.g  = '0;
		w.b  = '0;
		if (wr) begin
			a = ta;
			if (cur_opaque || cur_mode == MODE_COPY)
				a = 255;
			if (cur_blend_en && cur_const_alpha)
				a = ha;
			a = (a * p.cov) / 255;
			if (a == 255) begin
				w.r = tr;
				w.g = tg;
				w.b = tb;
			end else begin
				w.r = mix_channel(p.dr, tr, a);
				w.g = mix_channel(p.dg, tg, a);
				w.b = mix_channel(p.db, tb, a);
			end
		end
		return w;
	endfunction

	function automatic logic [13:0] pick_coord();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return 14'($urandom);
		endcase
	endfunction

	function automatic logic [31:0] pick_color();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	function automatic pixel_beat_t random_pixel();
		pixel_beat_t p;
		logic [23:0] dst;
		p.x   = pick_coord();
		p.y   = pick_coord();
		p.vis = ($urandom_range(0, 7) != 0);
		{p.sr, p.sg, p.sb, p.sa} = $urandom;
		case ($urandom_range(0, 5))
			0: p.sa = 8'h00;
			1: p.sa = 8'hFF;
			default: ;
		endcase
		// lean on the two register colours so select mode gets real hits
		case ($urandom_range(0, 3))
			0: dst = cur_high[31:8];
			1: dst = cur_low[31:8];
			default: dst = 24'($urandom);
		endcase
		{p.dr, p.dg, p.db} = dst;
		if ($urandom_range(0, 7) == 0)
			{p.sr, p.sg, p.sb} = dst;
		p.hi = ($urandom_range(0, 3) != 0);
		case ($urandom_range(0, 5))
			0: p.cov = 8'h00;
			1, 2: p.cov = 8'hFF;
			default: p.cov = 8'($urandom);
		endcase
		return p;
	endfunction

	task automatic queue_pixel(logic [13:0] x, logic [13:0] y, logic vis, logic [31:0] src,
			logic [23:0] dst, logic hi, logic [7:0] cov);
		pixel_beat_t p;
		p.x   = x;
		p.y   = y;
		p.vis = vis;
		{p.sr, p.sg, p.sb, p.sa} = src;
		{p.dr, p.dg, p.db} = dst;
		p.hi  = hi;
		p.cov = cov;
		pixel_backlog.insert(pixel_backlog.size(), p);
	endtask

	// sampled on the falling edge so it never races the clocked processes
	task automatic wait_idle();
		@(negedge clk);
		while (pixel_backlog.size() != 0 || pix_ch.valid || expected_writes.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we    <= 1'b0;
		case (idx)
			CFG_MODE:        cur_mode        = val[3:0];
			CFG_LOW_COLOR:   cur_low         = val;
			CFG_HIGH_COLOR:  cur_high        = val;
			CFG_SRC_OPAQUE:  cur_opaque      = val[0];
			CFG_BLEND_EN:    cur_blend_en    = val[0];
			CFG_CONST_ALPHA: cur_const_alpha = val[0];
			default: ;
		endcase
	endtask

	task automatic apply_setup(logic [3:0] mode, logic [31:0] low, logic [31:0] high,
			logic opq, logic ben, logic cal);
		wait_idle();
		write_reg(CFG_MODE, {28'd0, mode});
		write_reg(CFG_LOW_COLOR, low);
		write_reg(CFG_HIGH_COLOR, high);
		write_reg(CFG_SRC_OPAQUE, {31'd0, opq});
		write_reg(CFG_BLEND_EN, {31'd0, ben});
		write_reg(CFG_CONST_ALPHA, {31'd0, cal});
	endtask

	task automatic check_field(string name, int unsigned want, int unsigned got,
			fb_write_t ref_w);
		if (want != got) begin
			err_count++;
			$display("%0t: %s mismatch at (%0d,%0d): expected %0h, actual %0h",
				$time, name, ref_w.x, ref_w.y, want, got);
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		logic [31:0] lo_c, hi_c;
		arst_n               = 1'b0;
		cfg_we               = 1'b0;
		cfg_index            = CFG_MODE;
		cfg_wdata            = '0;
		pix_ch.valid         = 1'b0;
		pix_ch.pixel_x       = '0;
		pix_ch.pixel_y       = '0;
		pix_ch.visible       = 1'b0;
		pix_ch.source_red    = '0;
		pix_ch.source_green  = '0;
		pix_ch.source_blue   = '0;
		pix_ch.source_alpha  = '0;
		pix_ch.dest_red      = '0;
		pix_ch.dest_green    = '0;
		pix_ch.dest_blue     = '0;
		pix_ch.pattern_bit   = 1'b0;
		pix_ch.coverage      = '0;
		res_ch.ready         = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// reset defaults: copy mode, coordinate extremes, invisible, coverage ends
		queue_pixel(14'd0, 14'd0, 1'b1, 32'hFF008000, 24'h123456, 1'b0, 8'd255);
		queue_pixel(14'h3FFF, 14'h3FFF, 1'b0, 32'hFFFFFFFF, 24'hFFFFFF, 1'b1, 8'd255);
		queue_pixel(14'h3FFF, 14'd0, 1'b1, 32'hFF00FFFF, 24'h00FF00, 1'b1, 8'd0);
		queue_pixel(14'd0, 14'h3FFF, 1'b1, 32'h80FF4010, 24'hFF0000, 1'b0, 8'd128);

		apply_setup(MODE_OVER, DIR_LOW, DIR_HIGH, 1'b0, 1'b0, 1'b0);
		queue_pixel(14'd5, 14'd6, 1'b1, 32'h40608080, 24'hC0A020, 1'b1, 8'd255);
		queue_pixel(14'd7, 14'd8, 1'b1, 32'h406080FF, 24'hC0A020, 1'b0, 8'd255);
		apply_setup(MODE_ALPHA, DIR_LOW, DIR_HIGH, 1'b0, 1'b0, 1'b0);
		queue_pixel(14'd9, 14'd9, 1'b1, 32'hFFFFFF00, 24'h000000, 1'b1, 8'd255);
		apply_setup(MODE_ERASE, DIR_LOW, DIR_HIGH, 1'b0, 1'b0, 1'b0);
		queue_pixel(14'd1, 14'd2, 1'b1, 32'h11223344, 24'hF0E0D0, 1'b1, 8'd255);
		queue_pixel(14'd3, 14'd4, 1'b1, 32'h11223344, 24'hF0E0D0, 1'b0, 8'd255);
		apply_setup(MODE_INVERT, DIR_LOW, DIR_HIGH, 1'b0, 1'b0, 1'b0);
		queue_pixel(14'd10, 14'd11, 1'b1, 32'h11223344, 24'h0F80F0, 1'b1, 8'd200);
		queue_pixel(14'd12, 14'd13, 1'b1, 32'h11223344, 24'h0F80F0, 1'b0, 8'd200);
		apply_setup(MODE_ADD, DIR_LOW, DIR_HIGH, 1'b0, 1'b0, 1'b0);
		queue_pixel(14'd20, 14'd21, 1'b1, 32'hFF800100, 24'hFF8000, 1'b0, 8'd255);
		apply_setup(MODE_SUB, DIR_LOW, DIR_HIGH, 1'b0, 1'b0, 1'b0);
		queue_pixel(14'd22, 14'd23, 1'b1, 32'h1080FF00, 24'h208000, 1'b0, 8'd255);
		apply_setup(MODE_BLEND, DIR_LOW, DIR_HIGH, 1'b0, 1'b0, 1'b0);
		queue_pixel(14'd24, 14'd25, 1'b1, 32'hFF015500, 24'hFF0254, 1'b0, 8'd255);
		apply_setup(MODE_MIN, DIR_LOW, DIR_HIGH, 1'b0, 1'b0, 1'b0);
		queue_pixel(14'd30, 14'd31, 1'b1, 32'h00000080, 24'hFFFFFF, 1'b0, 8'd255);
		queue_pixel(14'd32, 14'd33, 1'b1, 32'hFFFFFF80, 24'h000000, 1'b0, 8'd255);
		apply_setup(MODE_MAX, DIR_LOW, DIR_HIGH, 1'b0, 1'b0, 1'b0);
		queue_pixel(14'd34, 14'd35, 1'b1, 32'hFFFFFF80, 24'h000000, 1'b0, 8'd255);
		queue_pixel(14'd36, 14'd37, 1'b1, 32'h40404080, 24'h404040, 1'b0, 8'd255);
		apply_setup(MODE_SELECT, DIR_LOW, DIR_HIGH, 1'b0, 1'b0, 1'b0);
		queue_pixel(14'd40, 14'd41, 1'b1, 32'h00000000, 24'hA0B0C0, 1'b1, 8'd255);
		queue_pixel(14'd42, 14'd43, 1'b1, 32'h00000000, 24'h102030, 1'b1, 8'd255);
		queue_pixel(14'd44, 14'd45, 1'b1, 32'h00000000, 24'h555555, 1'b1, 8'd255);
		queue_pixel(14'd46, 14'd47, 1'b1, 32'h00000000, 24'hA0B0C0, 1'b0, 8'd255);
		apply_setup(MODE_SPARE_LO, DIR_LOW, DIR_HIGH, 1'b0, 1'b0, 1'b0);
		queue_pixel(14'd50, 14'd51, 1'b1, 32'h20406060, 24'hE0C0A0, 1'b0, 8'd255);
		apply_setup(MODE_SPARE_HI, DIR_LOW, DIR_HIGH, 1'b0, 1'b0, 1'b0);
		queue_pixel(14'd52, 14'd53, 1'b1, 32'h204060A0, 24'hE0C0A0, 1'b1, 8'd240);
		apply_setup(MODE_OVER, DIR_LOW, DIR_HIGH, 1'b1, 1'b0, 1'b0);
		queue_pixel(14'd54, 14'd55, 1'b1, 32'h12345600, 24'hFEDCBA, 1'b0, 8'd255);
		apply_setup(MODE_ALPHA, DIR_LOW, DIR_HIGH, 1'b0, 1'b1, 1'b1);
		queue_pixel(14'd56, 14'd57, 1'b1, 32'h123456FF, 24'hFEDCBA, 1'b0, 8'd255);

		// one random phase per mode code, fresh register values each time
		for (int ph = 0; ph < 16; ph++) begin
			lo_c = pick_color();
			hi_c = ($urandom_range(0, 7) == 0) ? lo_c : pick_color();
			apply_setup(4'(ph), lo_c, hi_c, 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			for (int k = 0; k < PHASE_PIXELS; k++)
				pixel_backlog.insert(pixel_backlog.size(), random_pixel());
		end
		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0 && expected_writes.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// pixel sender: bursts of random length, random gaps between them
	always @(posedge clk) begin : drive_proc
		pixel_beat_t nxt;
		logic        send;
		send = 1'b0;
		nxt  = drive_px;
		if (pix_ch.valid && pix_ch.ready)
			expected_writes.insert(expected_writes.size(), blend_pixel(drive_px));
		if (pix_ch.valid && !pix_ch.ready) begin
			send = 1'b1;
		end else if (gap_left != 0) begin
			gap_left--;
		end else if (pixel_backlog.size() != 0) begin
			nxt  = pixel_backlog.pop_front();
			send = 1'b1;
			if (burst_left > 1) begin
				burst_left--;
			end else begin
				burst_left = $urandom_range(1, 24);
				gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			end
		end
		drive_px              = nxt;
		pix_ch.valid         <= send;
		pix_ch.pixel_x       <= nxt.x;
		pix_ch.pixel_y       <= nxt.y;
		pix_ch.visible       <= nxt.vis;
		pix_ch.source_red    <= nxt.sr;
		pix_ch.source_green  <= nxt.sg;
		pix_ch.source_blue   <= nxt.sb;
		pix_ch.source_alpha  <= nxt.sa;
		pix_ch.dest_red      <= nxt.dr;
		pix_ch.dest_green    <= nxt.dg;
		pix_ch.dest_blue     <= nxt.db;
		pix_ch.pattern_bit   <= nxt.hi;
		pix_ch.coverage      <= nxt.cov;
	end

	// write beat collector and receiver stall pattern
	always @(posedge clk) begin : collect_proc
		fb_write_t got, want;
		if (res_ch.valid && res_ch.ready) begin
			got.we = res_ch.write_enable;
			got.x  = res_ch.write_x;
			got.y  = res_ch.write_y;
			got.r  = res_ch.result_red;
			got.g  = res_ch.result_green;
			got.b  = res_ch.result_blue;
			writes_seen++;
			if (expected_writes.size() == 0) begin
				err_count++;
				$display("%0t: write beat with nothing expected: expected none, actual %h",
					$time, got);
			end else begin
				want = expected_writes.pop_front();
				check_field("write_enable", want.we, got.we, want);
				check_field("write_x", want.x, got.x, want);
				check_field("write_y", want.y, got.y, want);
				check_field("result_red", want.r, got.r, want);
				check_field("result_green", want.g, got.g, want);
				check_field("result_blue", want.b, got.b, want);
			end
		end
		// long hold-off while the sender is offering, so the pipe backs up
		if (hold_left == 0 && writes_seen >= next_hold_mark && pix_ch.valid) begin
			hold_left      = LONG_HOLD;
			next_hold_mark = next_hold_mark + 400;
		end
		if (pat_age == 0) begin
			stall_pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
			pat_age   = 64;
		end
		pat_age--;
		if (hold_left != 0) begin
			hold_left--;
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= stall_pat[pat_age[3:0]];
		end
	end

	always @(posedge clk) begin : watchdog_proc
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

endmodule

### files.f
+incdir+hdl
hdl/prb_pkg.sv
hdl/prb_if.sv
hdl/prb_rop.sv
hdl/prb_alpha.sv
hdl/prb_blend.sv
hdl/pixel_raster_op_blender_top.sv
verif/testbench.sv
